[hw/rtl/nlp_pkg.sv]
// ----------------------------------------------------------------------------
// nlp_pkg: shared types and constants for the permutation stepper
// Element width, packed word layout, the command codes and the response
// record used by the datapath and its port checker.
// ----------------------------------------------------------------------------
package nlp_pkg;

   // packed word layout: element i in bits 3i+2..3i
   localparam int ELEM_BITS  = 3;
   localparam int PACK_ELEMS = 8;
   localparam int WORD_BITS  = ELEM_BITS * PACK_ELEMS;
   localparam int LEN_BITS   = 4;

   typedef logic [ELEM_BITS-1:0] elem_type;
   typedef logic [LEN_BITS-1:0]  len_type;
   typedef logic [WORD_BITS-1:0] word_type;

   // request commands
   typedef enum logic [1:0] {
      OP_ADVANCE = 2'd0,
      OP_RESTART = 2'd1,
      OP_LOAD    = 2'd2
   } op_type;

   // response record
   typedef struct packed {
      word_type perm_word;
      logic     end_flag;
      logic     load_error;
   } rsp_type;

endpackage

[hw/rtl/next_lexicographic_permutation.sv]
// ----------------------------------------------------------------------------
// next_lexicographic_permutation: lexicographic permutation stepper
// Holds a permutation of 0..L-1 (L from csr_wr_data, clamped to 1..MAX_ELEMS
// and to 8) plus an end flag, and answers every request with the packed
// permutation after the command. A request is taken into an input register,
// and one pass of parallel compare and select logic (pivot search, successor
// swap, suffix reversal, or the load check) writes the new state and the
// result register once the response side is free: one request per cycle
// while the response side does not stall. The response register decouples
// the sides, so a new request is taken while a finished response waits. A
// length write reloads the identity and clears the end flag; the user must
// make it only while the block is idle (not enforced here). No clearing pass.
// ----------------------------------------------------------------------------
module next_lexicographic_permutation #(
   parameter int MAX_ELEMS = 8
) (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_wr_en,
   input  logic [3:0]  csr_wr_data,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [23:0] req_load_word,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [23:0] rsp_perm_word,
   output logic        rsp_end_flag,
   output logic        rsp_load_error
);

   localparam int ElemBits = nlp_pkg::ELEM_BITS;
   localparam int LenBits  = nlp_pkg::LEN_BITS;
   localparam int NumElems = (MAX_ELEMS < nlp_pkg::PACK_ELEMS) ? MAX_ELEMS
                                                              : nlp_pkg::PACK_ELEMS;

   typedef logic [NumElems-1:0][ElemBits-1:0] perm_type;

   // clamp a written length into 1..NumElems
   function automatic nlp_pkg::len_type clamp_len(input logic [3:0] raw);
      nlp_pkg::len_type n;
      if (raw == 4'd0) begin
         n = LenBits'(1);
      end else if (raw > 4'(NumElems)) begin
         n = LenBits'(NumElems);
      end else begin
         n = raw;
      end
      return n;
   endfunction

   // identity of length n, unused elements zero
   function automatic perm_type identity(input nlp_pkg::len_type n);
      perm_type p;
      for (int k = 0; k < NumElems; k++) begin
         p[k] = (LenBits'(k) < n) ? ElemBits'(k) : '0;
      end
      return p;
   endfunction

   // architectural state
   nlp_pkg::len_type  len_ff, len_in;
   perm_type          perm_ff, perm_in;
   logic              done_ff, done_in;

   // input register
   logic              in_vld_ff, in_vld_in;
   logic [1:0]        in_op_ff;
   nlp_pkg::word_type in_word_ff;

   // result register
   logic              rsp_vld_ff, rsp_vld_in;
   nlp_pkg::rsp_type  rsp_ff, rsp_in;

   logic              req_take;
   logic              step;

   // advance datapath
   logic              piv_found;
   nlp_pkg::len_type  piv_idx;
   nlp_pkg::elem_type piv_val;
   nlp_pkg::len_type  swp_idx;
   nlp_pkg::elem_type swp_val;
   perm_type          adv_perm;

   // load datapath
   perm_type          ld_perm;
   logic              ld_bad;
   logic              ld_err;

   // handshake
   assign step      = in_vld_ff && (!rsp_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !step;
   assign req_take  = req_valid && !req_stall;
   assign in_vld_in = req_take || (in_vld_ff && !step);
   assign rsp_vld_in = step || (rsp_vld_ff && rsp_stall);

   // pivot: highest k with p[k] < p[k+1] inside the active length
   always_comb begin
      piv_found = 1'b0;
      piv_idx   = '0;
      for (int k = 0; k < NumElems - 1; k++) begin
         if ((LenBits'(k + 1) < len_ff) && (perm_ff[k] < perm_ff[k + 1])) begin
            piv_found = 1'b1;
            piv_idx   = LenBits'(k);
         end
      end
   end

   // pivot value
   always_comb begin
      piv_val = '0;
      for (int m = 0; m < NumElems; m++) begin
         if (LenBits'(m) == piv_idx) begin
            piv_val = perm_ff[m];
         end
      end
   end

   // successor: rightmost element past the pivot that is larger than it
   always_comb begin
      swp_idx = '0;
      swp_val = '0;
      for (int m = 0; m < NumElems; m++) begin
         if ((LenBits'(m) > piv_idx) && (LenBits'(m) < len_ff) &&
             (perm_ff[m] > piv_val)) begin
            swp_idx = LenBits'(m);
            swp_val = perm_ff[m];
         end
      end
   end

   // swap pivot with successor, then reverse the suffix
   always_comb begin : adv_blk
      nlp_pkg::len_type  rev_idx;
      nlp_pkg::elem_type rev_val;
      rev_idx = '0;
      rev_val = '0;
      for (int k = 0; k < NumElems; k++) begin
         if (LenBits'(k) < piv_idx) begin
            adv_perm[k] = perm_ff[k];
         end else if (LenBits'(k) == piv_idx) begin
            adv_perm[k] = swp_val;
         end else if (LenBits'(k) < len_ff) begin
            // mirrored position inside the suffix
            rev_idx = len_ff + piv_idx - LenBits'(k);
            rev_val = '0;
            for (int m = 0; m < NumElems; m++) begin
               if (LenBits'(m) == rev_idx) begin
                  rev_val = perm_ff[m];
               end
            end
            adv_perm[k] = (rev_idx == swp_idx) ? piv_val : rev_val;
         end else begin
            adv_perm[k] = perm_ff[k];
         end
      end
   end

   // load check: range and pairwise uniqueness over the active elements
   always_comb begin
      ld_bad = 1'b0;
      for (int k = 0; k < NumElems; k++) begin
         ld_perm[k] = (LenBits'(k) < len_ff) ? in_word_ff[ElemBits*k +: ElemBits] : '0;
         if ((LenBits'(k) < len_ff) &&
             (LenBits'(in_word_ff[ElemBits*k +: ElemBits]) >= len_ff)) begin
            ld_bad = 1'b1;
         end
      end
      for (int a = 0; a < NumElems - 1; a++) begin
         for (int b = a + 1; b < NumElems; b++) begin
            if ((LenBits'(b) < len_ff) &&
                (in_word_ff[ElemBits*a +: ElemBits] == in_word_ff[ElemBits*b +: ElemBits])) begin
               ld_bad = 1'b1;
            end
         end
      end
   end

   // next state
   always_comb begin
      len_in  = len_ff;
      perm_in = perm_ff;
      done_in = done_ff;
      ld_err  = 1'b0;
      if (csr_wr_en) begin
         len_in  = clamp_len(csr_wr_data);
         perm_in = identity(clamp_len(csr_wr_data));
         done_in = 1'b0;
      end else if (step) begin
         case (nlp_pkg::op_type'(in_op_ff))
            nlp_pkg::OP_ADVANCE: begin
               if (!done_ff) begin
                  if (piv_found) begin
                     perm_in = adv_perm;
                  end else begin
                     // last permutation: wrap and mark the end
                     perm_in = identity(len_ff);
                     done_in = 1'b1;
                  end
               end
            end
            nlp_pkg::OP_RESTART: begin
               perm_in = identity(len_ff);
               done_in = 1'b0;
            end
            nlp_pkg::OP_LOAD: begin
               if (ld_bad) begin
                  ld_err = 1'b1;
               end else begin
                  perm_in = ld_perm;
                  done_in = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // response payload from the new state
   always_comb begin
      rsp_in = '0;
      for (int k = 0; k < NumElems; k++) begin
         rsp_in.perm_word[ElemBits*k +: ElemBits] = perm_in[k];
      end
      rsp_in.end_flag   = done_in;
      rsp_in.load_error = ld_err;
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff     <= clamp_len(4'd8);
         perm_ff    <= identity(clamp_len(4'd8));
         done_ff    <= 1'b0;
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         len_ff     <= len_in;
         perm_ff    <= perm_in;
         done_ff    <= done_in;
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff   <= req_opcode;
         in_word_ff <= req_load_word;
      end
      if (step) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid      = rsp_vld_ff;
   assign rsp_perm_word  = rsp_ff.perm_word;
   assign rsp_end_flag   = rsp_ff.end_flag;
   assign rsp_load_error = rsp_ff.load_error;

endmodule

[hw/rtl/nlp_checker.sv]
// ----------------------------------------------------------------------------
// nlp_checker: port-level checks for the permutation stepper
// Watches the top-level ports and flags stall, reset and response-content
// violations; bound to the top level below.
// ----------------------------------------------------------------------------
module nlp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [23:0] rsp_perm_word,
   input logic        rsp_end_flag,
   input logic        rsp_load_error
);

   localparam int ElemBits = nlp_pkg::ELEM_BITS;
   localparam int Elems    = nlp_pkg::PACK_ELEMS;

   logic ident_ok;
   logic dup_seen;

   // response word past element 0 is an identity prefix followed by zeros
   always_comb begin : ident_blk
      logic in_tail;
      in_tail  = 1'b0;
      ident_ok = 1'b1;
      for (int k = 1; k < Elems; k++) begin
         if (in_tail) begin
            if (rsp_perm_word[ElemBits*k +: ElemBits] != '0) begin
               ident_ok = 1'b0;
            end
         end else if (rsp_perm_word[ElemBits*k +: ElemBits] == ElemBits'(k)) begin
            in_tail = 1'b0;
         end else if (rsp_perm_word[ElemBits*k +: ElemBits] == '0) begin
            in_tail = 1'b1;
         end else begin
            ident_ok = 1'b0;
         end
      end
   end

   // any nonzero element appearing twice
   always_comb begin
      dup_seen = 1'b0;
      for (int a = 0; a < Elems - 1; a++) begin
         for (int b = a + 1; b < Elems; b++) begin
            if ((rsp_perm_word[ElemBits*a +: ElemBits] ==
                 rsp_perm_word[ElemBits*b +: ElemBits]) &&
                (rsp_perm_word[ElemBits*a +: ElemBits] != '0)) begin
               dup_seen = 1'b1;
            end
         end
      end
   end

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_perm_word) &&
                                 $stable(rsp_end_flag) && $stable(rsp_load_error))
      else $error("stalled response changed");

   // requests are held back only behind a blocked response
   a_stall_cause: assert property (@(posedge clock)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stall without a blocked response");

   // reset empties both registers
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

   // after a wrap the permutation shown is the identity
   a_end_ident: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_flag |-> ident_ok)
      else $error("end flag set on a non-identity permutation");

   // every response is a permutation: no repeated nonzero element
   a_no_dup: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !dup_seen)
      else $error("repeated element in response");

endmodule

bind next_lexicographic_permutation nlp_checker u_nlp_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_perm_word  (rsp_perm_word),
   .rsp_end_flag   (rsp_end_flag),
   .rsp_load_error (rsp_load_error)
);
